// ----- rtl/q_learning_dvfs_governor_core_macros.svh -----
// ----------------------------------------------------------------------------
// q_learning_dvfs_governor_core_macros
// Assertion helpers for the governor core, clocked on clock, held off in reset.
// ----------------------------------------------------------------------------
`ifndef Q_LEARNING_DVFS_GOVERNOR_CORE_MACROS_SVH
`define Q_LEARNING_DVFS_GOVERNOR_CORE_MACROS_SVH

// consequent checked in the same cycle
`define QLDG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define QLDG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/qldg_pkg.sv -----
// ----------------------------------------------------------------------------
// qldg_pkg
// Shared widths, codes and control structs for the governor core.
// ----------------------------------------------------------------------------
package qldg_pkg;

   localparam int STATE_W  = 6;
   localparam int VALUE_W  = 17;
   localparam int REWARD_W = 18;
   localparam int T_W      = 35;
   localparam int MUL_A_W  = 17;
   localparam int MUL_B_W  = 20;
   localparam int PROD_W   = 37;
   localparam int ACC_W    = 52;
   localparam int DELTA_W  = 22;
   localparam int SUM_W    = 23;

   localparam logic [1:0] ACT_DOWN = 2'd0;
   localparam logic [1:0] ACT_STAY = 2'd1;
   localparam logic [1:0] ACT_UP   = 2'd2;
   localparam logic [1:0] ACT_RSVD = 2'd3;

   localparam logic [1:0] MUL_GB = 2'd0;   // gamma * best
   localparam logic [1:0] MUL_AL = 2'd1;   // alpha * low half of T
   localparam logic [1:0] MUL_AH = 2'd2;   // alpha * high half of T

   localparam logic [1:0] CSR_ALPHA    = 2'd0;
   localparam logic [1:0] CSR_GAMMA    = 2'd1;
   localparam logic [1:0] CSR_THRESH   = 2'd2;
   localparam logic [1:0] CSR_LEARN_ON = 2'd3;

   localparam logic [15:0] ALPHA_RST  = 16'd3277;
   localparam logic [15:0] GAMMA_RST  = 16'd24576;
   localparam logic [15:0] THRESH_RST = 16'd32767;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 17'sd65535;

   typedef struct packed {
      logic       load_in;
      logic       read_lo;
      logic       read_hi;
      logic       decide;
      logic       mul_en;
      logic [1:0] mul_op;
      logic       load_t;
      logic       load_acc;
      logic       commit;
      logic       report;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

// ----- rtl/qldg_ctrl.sv -----
// ----------------------------------------------------------------------------
// qldg_ctrl
// Sequencer for one governor tick: value reads, decision, multiply steps, commit,
// or a report of the current value when learning is off.
module qldg_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             learning_on,
   input  qldg_pkg::sts_type sts,
   output logic             req_stall,
   output qldg_pkg::cmd_type cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD0  = 4'd1;
   localparam logic [3:0] ST_RD1  = 4'd2;
   localparam logic [3:0] ST_DEC  = 4'd3;
   localparam logic [3:0] ST_RPT  = 4'd4;
   localparam logic [3:0] ST_MGB  = 4'd5;
   localparam logic [3:0] ST_TSUM = 4'd6;
   localparam logic [3:0] ST_MAL  = 4'd7;
   localparam logic [3:0] ST_MAH  = 4'd8;
   localparam logic [3:0] ST_ACC  = 4'd9;
   localparam logic [3:0] ST_UPD  = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_RD0;
            end
         end
         ST_RD0: begin
            cmd.read_lo = 1'b1;
            state_in    = ST_RD1;
         end
         ST_RD1: begin
            cmd.read_hi = 1'b1;
            state_in    = ST_DEC;
         end
         ST_DEC: begin
            if (learning_on) begin
               cmd.decide = 1'b1;
               state_in   = ST_MGB;
            end else begin
               state_in = ST_RPT;
            end
         end
         ST_RPT: begin
            if (sts.out_free) begin
               cmd.report = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_MGB: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = qldg_pkg::MUL_GB;
            state_in   = ST_TSUM;
         end
         ST_TSUM: begin
            cmd.load_t = 1'b1;
            state_in   = ST_MAL;
         end
         ST_MAL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = qldg_pkg::MUL_AL;
            state_in   = ST_MAH;
         end
         ST_MAH: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = qldg_pkg::MUL_AH;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.load_acc = 1'b1;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ----- rtl/qldg_dpath.sv -----
// ----------------------------------------------------------------------------
// qldg_dpath
// Value store, reward, greedy choice, shared multiplier, TD update and result
// register of the governor core.
// ----------------------------------------------------------------------------
module qldg_dpath #(
   parameter int NUM_STATES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  qldg_pkg::cmd_type        cmd,
   output qldg_pkg::sts_type        sts,
   input  logic [15:0]              alpha_q15,
   input  logic [15:0]              gamma_q15,
   input  logic [15:0]              explore_threshold,
   input  logic [15:0]              req_cpu_perf,
   input  logic signed [15:0]       req_temperature_q8,
   input  logic [15:0]              req_random_draw,
   input  logic [1:0]               req_random_action,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic [5:0]               rsp_next_state,
   output logic [1:0]               rsp_chosen_action,
   output logic                     rsp_explored,
   output logic signed [16:0]       rsp_updated_value
);

   localparam int AW  = $clog2(NUM_STATES);
   localparam int SW  = qldg_pkg::STATE_W;
   localparam int VW  = qldg_pkg::VALUE_W;
   localparam int RW  = qldg_pkg::REWARD_W;
   localparam int TW  = qldg_pkg::T_W;
   localparam int AWM = qldg_pkg::MUL_A_W;
   localparam int BWM = qldg_pkg::MUL_B_W;
   localparam int PW  = qldg_pkg::PROD_W;
   localparam int CW  = qldg_pkg::ACC_W;
   localparam int DW  = qldg_pkg::DELTA_W;
   localparam int UW  = qldg_pkg::SUM_W;
   localparam logic [SW-1:0] LAST_STATE = SW'(NUM_STATES - 1);

   // value store
   logic signed [VW-1:0] value_mem_ff [NUM_STATES];
   logic [NUM_STATES-1:0] vld_ff;
   logic signed [VW-1:0] rd_a_ff, rd_b_ff;
   logic                 rd_a_vld_ff, rd_b_vld_ff;
   logic signed [VW-1:0] rd_a_val, rd_b_val;
   logic [AW-1:0]        addr_a, addr_b;

   // tick state
   logic [SW-1:0]        cur_state_ff;
   logic [SW-1:0]        s_down, s_up, ns_c;
   logic signed [RW-1:0] reward_ff;
   logic                 explore_ff;
   logic [1:0]           ract_ff;
   logic signed [VW-1:0] v_ff, vd_ff, best_ff, best_c, mx_dv;
   logic [1:0]           act_ff, act_c, greedy_act;
   logic                 at_end;

   // reward
   logic signed [26:0]   rwd_num, rwd_q;

   // arithmetic
   logic signed [AWM-1:0] mul_a;
   logic signed [BWM-1:0] mul_b;
   logic signed [PW-1:0]  mul_p, prod_ff;
   logic [31:0]           lo_ff;
   logic signed [TW-1:0]  t_ff, t_c;
   logic signed [CW-1:0]  acc_ff, acc_c, acc_q;
   logic signed [DW-1:0]  delta_c;
   logic signed [UW-1:0]  sum_c;
   logic signed [VW-1:0]  new_value;

   // result register
   logic                 rsp_valid_ff;
   logic [SW-1:0]        rsp_state_ff;
   logic [1:0]           rsp_act_ff;
   logic                 rsp_expl_ff;
   logic signed [VW-1:0] rsp_value_ff;

   // reward = trunc(((100 - cpu) * 256 - temp) / 256)
   assign rwd_num = ((27'sd100 - $signed({11'b0, req_cpu_perf})) <<< 8)
                    - $signed({{11{req_temperature_q8[15]}}, req_temperature_q8});
   assign rwd_q   = (rwd_num >>> 8)
                    + $signed({26'b0, (rwd_num[26] && (rwd_num[7:0] != 8'd0))});

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         reward_ff  <= rwd_q[RW-1:0];
         explore_ff <= (req_random_draw > explore_threshold);
         ract_ff    <= req_random_action;
      end
   end

   // neighbours, clamped at the ends
   assign s_down = (cur_state_ff == '0) ? cur_state_ff : cur_state_ff - SW'(1);
   assign s_up   = (cur_state_ff >= LAST_STATE) ? cur_state_ff : cur_state_ff + SW'(1);
   assign at_end = (cur_state_ff == '0) || (cur_state_ff >= LAST_STATE);

   assign addr_a = cmd.read_hi ? s_up[AW-1:0] : cur_state_ff[AW-1:0];
   assign addr_b = s_down[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.read_lo || cmd.read_hi) begin
         rd_a_ff     <= value_mem_ff[addr_a];
         rd_a_vld_ff <= vld_ff[addr_a];
      end
      if (cmd.read_lo) begin
         rd_b_ff     <= value_mem_ff[addr_b];
         rd_b_vld_ff <= vld_ff[addr_b];
      end
      if (cmd.commit) begin
         value_mem_ff[cur_state_ff[AW-1:0]] <= new_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.commit) begin
         vld_ff[cur_state_ff[AW-1:0]] <= 1'b1;
      end
   end

   // entries never written read as zero
   assign rd_a_val = rd_a_vld_ff ? rd_a_ff : '0;
   assign rd_b_val = rd_b_vld_ff ? rd_b_ff : '0;

   // decision: rd_a holds the up neighbour here
   always_comb begin
      mx_dv  = (v_ff > vd_ff) ? v_ff : vd_ff;
      best_c = (rd_a_val > mx_dv) ? rd_a_val : mx_dv;
      if (v_ff > vd_ff) begin
         greedy_act = (rd_a_val > v_ff) ? qldg_pkg::ACT_UP : qldg_pkg::ACT_STAY;
      end else begin
         greedy_act = (rd_a_val > vd_ff) ? qldg_pkg::ACT_UP : qldg_pkg::ACT_DOWN;
      end
      priority if (explore_ff) begin
         act_c = (ract_ff == qldg_pkg::ACT_RSVD) ? qldg_pkg::ACT_STAY : ract_ff;
      end else if (at_end) begin
         act_c = qldg_pkg::ACT_DOWN;
      end else begin
         act_c = greedy_act;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_hi) begin
         v_ff  <= rd_a_val;
         vd_ff <= rd_b_val;
      end
      if (cmd.decide) begin
         best_ff <= best_c;
         act_ff  <= act_c;
      end
   end

   // shared multiplier
   always_comb begin
      unique case (cmd.mul_op)
         qldg_pkg::MUL_GB: begin
            mul_a = $signed({1'b0, gamma_q15});
            mul_b = $signed({{(BWM - VW){best_ff[VW-1]}}, best_ff});
         end
         qldg_pkg::MUL_AL: begin
            mul_a = $signed({1'b0, alpha_q15});
            mul_b = $signed({4'b0, t_ff[15:0]});
         end
         qldg_pkg::MUL_AH: begin
            mul_a = $signed({1'b0, alpha_q15});
            mul_b = $signed({t_ff[TW-1], t_ff[TW-1:16]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // T = reward*2^15 + gamma*best - V*2^15
   assign t_c = ($signed({{(TW - RW){reward_ff[RW-1]}}, reward_ff}) <<< 15)
                + $signed(prod_ff[TW-1:0])
                - ($signed({{(TW - VW){v_ff[VW-1]}}, v_ff}) <<< 15);

   assign acc_c = ($signed({{(CW - PW){prod_ff[PW-1]}}, prod_ff}) <<< 16)
                  + $signed({20'b0, lo_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
         if (cmd.mul_op == qldg_pkg::MUL_AH) begin
            lo_ff <= prod_ff[31:0];
         end
      end
      if (cmd.load_t) begin
         t_ff <= t_c;
      end
      if (cmd.load_acc) begin
         acc_ff <= acc_c;
      end
   end

   // delta = trunc(alpha*T / 2^30), then saturate V + delta
   assign acc_q   = acc_ff >>> 30;
   assign delta_c = acc_q[DW-1:0]
                    + $signed({{(DW - 1){1'b0}}, (acc_ff[CW-1] && (acc_ff[29:0] != '0))});
   assign sum_c   = $signed({{(UW - VW){v_ff[VW-1]}}, v_ff})
                    + $signed({delta_c[DW-1], delta_c});

   always_comb begin
      priority if (sum_c > $signed({{(UW - VW){1'b0}}, qldg_pkg::VALUE_MAX})) begin
         new_value = qldg_pkg::VALUE_MAX;
      end else if (sum_c < -$signed({{(UW - VW){1'b0}}, qldg_pkg::VALUE_MAX})) begin
         new_value = -qldg_pkg::VALUE_MAX;
      end else begin
         new_value = sum_c[VW-1:0];
      end
   end

   always_comb begin
      unique case (act_ff)
         qldg_pkg::ACT_DOWN: ns_c = s_down;
         qldg_pkg::ACT_UP:   ns_c = s_up;
         default:            ns_c = cur_state_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_state_ff <= '0;
      end else if (cmd.commit) begin
         cur_state_ff <= ns_c;
      end
   end

   // result register
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit || cmd.report) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_state_ff <= ns_c;
         rsp_act_ff   <= act_ff;
         rsp_expl_ff  <= explore_ff;
         rsp_value_ff <= new_value;
      end else if (cmd.report) begin
         rsp_state_ff <= cur_state_ff;
         rsp_act_ff   <= qldg_pkg::ACT_STAY;
         rsp_expl_ff  <= 1'b0;
         rsp_value_ff <= v_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_state    = rsp_state_ff;
   assign rsp_chosen_action = rsp_act_ff;
   assign rsp_explored      = rsp_expl_ff;
   assign rsp_updated_value = rsp_value_ff;

endmodule

// ----- rtl/q_learning_dvfs_governor_core.sv -----
// ----------------------------------------------------------------------------
// q_learning_dvfs_governor_core
// Tabular TD learner that steps a frequency level down, holds it or steps it
// up once per tick. One tick is in flight at a time and req_stall stays high
// until its result is loaded into the output register. With learning on a
// tick runs three value-store reads over its two read ports, the decision,
// then gamma*best and the two halves of alpha*T through one shared 17x20
// multiplier, an accumulate, and the truncate/saturate/write-back step.
// With learning off a tick skips the update and reports the stored value.
// A full result register that is held by rsp_stall delays the final step.
// The value store reads as zero after reset through per-entry valid bits;
// there is no clearing pass.
// ----------------------------------------------------------------------------
`include "q_learning_dvfs_governor_core_macros.svh"

module q_learning_dvfs_governor_core #(
   parameter int NUM_STATES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_cpu_perf,
   input  logic signed [15:0] req_temperature_q8,
   input  logic [15:0]        req_random_draw,
   input  logic [1:0]         req_random_action,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_next_state,
   output logic [1:0]         rsp_chosen_action,
   output logic               rsp_explored,
   output logic signed [16:0] rsp_updated_value,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   logic [15:0] alpha_ff;
   logic [15:0] gamma_ff;
   logic [15:0] thresh_ff;
   logic        learn_on_ff;

   qldg_pkg::cmd_type cmd;
   qldg_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= qldg_pkg::ALPHA_RST;
         gamma_ff    <= qldg_pkg::GAMMA_RST;
         thresh_ff   <= qldg_pkg::THRESH_RST;
         learn_on_ff <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            qldg_pkg::CSR_ALPHA:    alpha_ff    <= csr_wdata;
            qldg_pkg::CSR_GAMMA:    gamma_ff    <= csr_wdata;
            qldg_pkg::CSR_THRESH:   thresh_ff   <= csr_wdata;
            qldg_pkg::CSR_LEARN_ON: learn_on_ff <= csr_wdata[0];
         endcase
      end
   end

   qldg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .learning_on (learn_on_ff),
      .sts         (sts),
      .req_stall   (req_stall),
      .cmd         (cmd)
   );

   qldg_dpath #(
      .NUM_STATES (NUM_STATES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .alpha_q15          (alpha_ff),
      .gamma_q15          (gamma_ff),
      .explore_threshold  (thresh_ff),
      .req_cpu_perf       (req_cpu_perf),
      .req_temperature_q8 (req_temperature_q8),
      .req_random_draw    (req_random_draw),
      .req_random_action  (req_random_action),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_next_state     (rsp_next_state),
      .rsp_chosen_action  (rsp_chosen_action),
      .rsp_explored       (rsp_explored),
      .rsp_updated_value  (rsp_updated_value)
   );

   `QLDG_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "item accepted but core not busy")
   `QLDG_ASSERT_NOW(a_state_in_range, rsp_valid, int'(rsp_next_state) < NUM_STATES, "level out of range")
   `QLDG_ASSERT_NOW(a_value_saturated, rsp_valid, rsp_updated_value != 17'h10000, "value not saturated")
   `QLDG_ASSERT_NOW(a_action_code, rsp_valid, rsp_chosen_action != qldg_pkg::ACT_RSVD, "bad action code")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Q-learning DVFS governor core. Every accepted
// tick goes through a local model of the value store, the explore/exploit
// choice, the saturated TD update and the clamped level move. Each result
// item is compared with the oldest prediction. Directed ticks cover field
// extremes, both ends of the level range and learning off. Random phases
// then sweep the learning rate, discount, threshold and mode registers,
// with idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NUM_LEVELS  = 16;
   localparam int QUIET_LIMIT = 5000;
   localparam int PHASES      = 12;
   localparam int PHASE_TICKS = 95;

   typedef struct packed {
      logic [15:0]        cpu_perf;
      logic signed [15:0] temperature_q8;
      logic [15:0]        random_draw;
      logic [1:0]         random_action;
   } tick_type;

   typedef struct packed {
      logic [5:0]         next_state;
      logic [1:0]         chosen_action;
      logic               explored;
      logic signed [16:0] updated_value;
   } outcome_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [15:0]        req_cpu_perf;
   logic signed [15:0] req_temperature_q8;
   logic [15:0]        req_random_draw;
   logic [1:0]         req_random_action;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [5:0]         rsp_next_state;
   logic [1:0]         rsp_chosen_action;
   logic               rsp_explored;
   logic signed [16:0] rsp_updated_value;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;

   // governor model state
   int          level_value [NUM_LEVELS];
   int          level;
   logic [15:0] alpha_q;
   logic [15:0] gamma_q;
   logic [15:0] draw_limit;
   logic        learn_on;

   outcome_type pending_outcomes[$];
   int          idle_pct = 14;
   int          ticks_sent;
   int          results_checked;
   int          settings_used;
   int          error_count;
   int          quiet_cycles;

   q_learning_dvfs_governor_core #(.NUM_STATES(NUM_LEVELS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cpu_perf       (req_cpu_perf),
      .req_temperature_q8 (req_temperature_q8),
      .req_random_draw    (req_random_draw),
      .req_random_action  (req_random_action),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_next_state     (rsp_next_state),
      .rsp_chosen_action  (rsp_chosen_action),
      .rsp_explored       (rsp_explored),
      .rsp_updated_value  (rsp_updated_value),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int neighbour(input int s, input logic [1:0] act);
      if (act == qldg_pkg::ACT_DOWN) return (s == 0) ? 0 : s - 1;
      if (act == qldg_pkg::ACT_UP) return (s >= NUM_LEVELS - 1) ? s : s + 1;
      return s;
   endfunction

   function automatic outcome_type governor_step(input tick_type t);
      int          reward;
      int          v;
      int          best;
      int          nv;
      longint      td;
      longint      delta;
      longint      sum;
      logic [1:0]  act;
      logic        go_random;
      outcome_type o;
      reward = ((100 - int'(t.cpu_perf)) * 256 - int'($signed(t.temperature_q8))) / 256;
      v = level_value[level];
      if (!learn_on) begin
         o.next_state    = 6'(level);
         o.chosen_action = qldg_pkg::ACT_STAY;
         o.explored      = 1'b0;
         o.updated_value = 17'(v);
         return o;
      end
      go_random = t.random_draw > draw_limit;
      if (go_random) begin
         act = (t.random_action == qldg_pkg::ACT_RSVD) ? qldg_pkg::ACT_STAY
                                                       : t.random_action;
      end else if (level == 0 || level >= NUM_LEVELS - 1) begin
         act = qldg_pkg::ACT_DOWN;
      end else begin
         act = qldg_pkg::ACT_DOWN;
         best = level_value[level - 1];
         if (level_value[level] > best) begin
            best = level_value[level];
            act = qldg_pkg::ACT_STAY;
         end
         if (level_value[level + 1] > best) act = qldg_pkg::ACT_UP;
      end
      best = level_value[neighbour(level, qldg_pkg::ACT_DOWN)];
      if (level_value[level] > best) best = level_value[level];
      if (level_value[neighbour(level, qldg_pkg::ACT_UP)] > best)
         best = level_value[neighbour(level, qldg_pkg::ACT_UP)];
      td = longint'(reward) * 32768 + longint'(gamma_q) * longint'(best)
           - longint'(v) * 32768;
      delta = (longint'(alpha_q) * td) / 1073741824;
      sum = longint'(v) + delta;
      if (sum > 65535) sum = 65535;
      if (sum < -65535) sum = -65535;
      nv = int'(sum);
      level_value[level] = nv;
      level = neighbour(level, act);
      o.next_state    = 6'(level);
      o.chosen_action = act;
      o.explored      = go_random;
      o.updated_value = 17'(nv);
      return o;
   endfunction

   function automatic tick_type random_tick();
      int       d;
      tick_type t;
      t.cpu_perf = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 250));
      t.temperature_q8 = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'(int'($urandom_range(0, 25600)) - 6400);
      if ($urandom_range(0, 1) == 0) begin
         d = int'(draw_limit) + int'($urandom_range(0, 4)) - 2;
         if (d < 0) d = 0;
         if (d > 65535) d = 65535;
         t.random_draw = 16'(d);
      end else begin
         t.random_draw = 16'($urandom);
      end
      t.random_action = 2'($urandom_range(0, 3));
      return t;
   endfunction

   task automatic send_tick(input tick_type t);
      int gap;
      if ($urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cpu_perf       <= t.cpu_perf;
      req_temperature_q8 <= t.temperature_q8;
      req_random_draw    <= t.random_draw;
      req_random_action  <= t.random_action;
      do @(posedge clock); while (req_stall);
      pending_outcomes.push_back(governor_step(t));
      ticks_sent++;
   endtask

   task automatic send_fields(input logic [15:0] cpu, input logic [15:0] temp,
                              input logic [15:0] draw, input logic [1:0] act);
      send_tick('{cpu, temp, draw, act});
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         qldg_pkg::CSR_ALPHA:    alpha_q = data;
         qldg_pkg::CSR_GAMMA:    gamma_q = data;
         qldg_pkg::CSR_THRESH:   draw_limit = data;
         qldg_pkg::CSR_LEARN_ON: learn_on = data[0];
      endcase
   endtask

   task automatic test_field_extremes();
      send_fields(16'd0, 16'h7FFF, 16'd0, qldg_pkg::ACT_DOWN);
      send_fields(16'hFFFF, 16'h8000, 16'hFFFF, qldg_pkg::ACT_RSVD);
      send_fields(16'd100, 16'h0000, 16'd32768, qldg_pkg::ACT_UP);
      send_fields(16'd100, 16'hFFFF, 16'd32767, qldg_pkg::ACT_STAY);
      send_fields(16'd101, 16'h00FF, 16'd1, qldg_pkg::ACT_UP);
      send_fields(16'hAAAA, 16'h5555, 16'h5555, qldg_pkg::ACT_DOWN);
      send_fields(16'h5555, 16'hAAAA, 16'hAAAA, qldg_pkg::ACT_UP);
      drain();
   endtask

   task automatic test_level_ends();
      csr_write(qldg_pkg::CSR_ALPHA, 16'd32768);
      csr_write(qldg_pkg::CSR_GAMMA, 16'd32768);
      csr_write(qldg_pkg::CSR_THRESH, 16'd0);
      settings_used++;
      repeat (16)
         send_fields(16'($urandom_range(0, 200)), 16'($urandom),
                     16'($urandom_range(1, 65535)), qldg_pkg::ACT_UP);
      send_fields(16'd0, 16'd0, 16'hFFFF, qldg_pkg::ACT_RSVD);
      drain();
      csr_write(qldg_pkg::CSR_THRESH, 16'hFFFF);
      settings_used++;
      send_fields(16'd50, 16'd0, 16'hFFFF, qldg_pkg::ACT_UP);
      drain();
   endtask

   task automatic test_learning_off();
      csr_write(qldg_pkg::CSR_LEARN_ON, 16'hFFFE);
      settings_used++;
      send_fields(16'd0, 16'h8000, 16'hFFFF, qldg_pkg::ACT_UP);
      send_fields(16'hFFFF, 16'h7FFF, 16'd0, qldg_pkg::ACT_DOWN);
      drain();
      csr_write(qldg_pkg::CSR_LEARN_ON, 16'h0001);
   endtask

   task automatic test_random_phases();
      logic [15:0] a;
      logic [15:0] g;
      logic [15:0] th;
      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: a = 16'd0;
            1: a = 16'd32768;
            2: a = 16'hFFFF;
            default: a = 16'($urandom_range(0, 32768));
         endcase
         case (p % 3)
            0: g = 16'd0;
            1: g = 16'd32768;
            default: g = (p < 6) ? 16'hFFFF : 16'($urandom_range(0, 32768));
         endcase
         case (p % 5)
            0: th = 16'd0;
            1: th = 16'hFFFF;
            default: th = 16'($urandom);
         endcase
         csr_write(qldg_pkg::CSR_ALPHA, a);
         csr_write(qldg_pkg::CSR_GAMMA, g);
         csr_write(qldg_pkg::CSR_THRESH, th);
         csr_write(qldg_pkg::CSR_LEARN_ON, {15'($urandom), (p != 5 && p != 10)});
         settings_used++;
         idle_pct = (p == 7) ? 0 : 14;
         for (int i = 0; i < PHASE_TICKS; i++) begin
            if (i == 40) drain();
            send_tick(random_tick());
         end
         drain();
      end
      idle_pct = 14;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < idle_pct);
   end

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_next_state, rsp_chosen_action, rsp_explored, rsp_updated_value};
         if (pending_outcomes.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: unexpected result item: state %0d act %0d expl %0b value %0d",
                        $realtime, got.next_state, got.chosen_action, got.explored,
                        $signed(got.updated_value));
         end else begin
            want = pending_outcomes.pop_front();
            results_checked++;
            if (got.next_state !== want.next_state || got.chosen_action !== want.chosen_action ||
                got.explored !== want.explored || got.updated_value !== want.updated_value) begin
               error_count++;
               if (error_count <= 10)
                  $display({"%0t: mismatch: expected state %0d act %0d expl %0b value %0d,",
                            " got state %0d act %0d expl %0b value %0d"},
                           $realtime, want.next_state, want.chosen_action, want.explored,
                           $signed(want.updated_value), got.next_state, got.chosen_action,
                           got.explored, $signed(got.updated_value));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d cycles without an item moving", quiet_cycles);
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_cpu_perf       = '0;
      req_temperature_q8 = '0;
      req_random_draw    = '0;
      req_random_action  = '0;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      foreach (level_value[i]) level_value[i] = 0;
      level      = 0;
      alpha_q    = qldg_pkg::ALPHA_RST;
      gamma_q    = qldg_pkg::GAMMA_RST;
      draw_limit = qldg_pkg::THRESH_RST;
      learn_on   = 1'b1;
      settings_used = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_level_ends();
      test_learning_off();
      test_random_phases();

      drain();
      repeat (20) @(posedge clock);
      if (pending_outcomes.size() != 0) error_count += pending_outcomes.size();
      $display("run covered %0d ticks under %0d register settings, %0d results checked",
               ticks_sent, settings_used, results_checked);
      $display("errors counted: %0d", error_count);
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
